// File: hw/rtl/dfas_pkg.sv
// ----------------------------------------------------------------------------
// dfas_pkg
// Shared types, constants and leading-zero count of the binary64 add/subtract pipeline.
// ----------------------------------------------------------------------------
package dfas_pkg;

    localparam logic [63:0] QNAN_BITS = 64'h7ff8000000000000;
    localparam int          EXP_BIAS  = 1023;

    typedef struct packed {
        logic        special;
        logic [63:0] special_bits;
        logic        sign;
        logic [12:0] ex;
        logic [56:0] sig;
    } dfas_mid_t;

    function automatic logic [5:0] dfas_lzc(input logic [56:0] v);
        logic [5:0] n;
        logic       hit;
        n   = 6'd57;
        hit = 1'b0;
        for (int i = 56; i >= 0; i--)
        begin
            if (!hit && v[i])
            begin
                n   = 6'(56 - i);
                hit = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

// File: hw/rtl/dfas_align.sv
// ----------------------------------------------------------------------------
// dfas_align
// Stage 1-2: classify, unpack, order operands, align with sticky and add/subtract.
// ----------------------------------------------------------------------------
module dfas_align
    import dfas_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic        req_type,
    input  logic [63:0] operand_a,
    input  logic [63:0] operand_b,
    output logic        out_valid,
    output dfas_mid_t   out_mid
);

    logic [63:0] a, b;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic        spec;
    logic [63:0] spec_bits;
    logic [12:0] ea, eb;
    logic [55:0] ma, mb;
    logic        swap;

    logic        v1_reg;
    logic        spec1_reg, sa1_reg, sb1_reg;
    logic [63:0] sbits1_reg;
    logic [12:0] ex1_reg;
    logic [12:0] d1_reg;
    logic [55:0] mbig1_reg, msml1_reg;

    logic [55:0] shifted, lostmask;
    logic [55:0] mb_al;
    logic        v2_reg;
    dfas_mid_t   mid2_reg;
    dfas_mid_t   mid2_next;

    assign a = operand_a;
    assign b = {operand_b[63] ^ req_type, operand_b[62:0]};

    assign a_nan  = (a[62:52] == 11'h7ff) && (a[51:0] != '0);
    assign b_nan  = (b[62:52] == 11'h7ff) && (b[51:0] != '0);
    assign a_inf  = (a[62:52] == 11'h7ff) && (a[51:0] == '0);
    assign b_inf  = (b[62:52] == 11'h7ff) && (b[51:0] == '0);
    assign a_zero = (a[62:0] == '0);
    assign b_zero = (b[62:0] == '0);

    always_comb
    begin
        spec      = 1'b1;
        spec_bits = '0;
        if (a_nan || b_nan)
            spec_bits = QNAN_BITS;
        else if (a_inf)
            spec_bits = (b_inf && (a[63] ^ b[63])) ? QNAN_BITS : a;
        else if (b_inf)
            spec_bits = b;
        else if (a_zero)
            spec_bits = b_zero ? {a[63] & b[63], 63'd0} : b;
        else if (b_zero)
            spec_bits = a;
        else
            spec = 1'b0;
    end

    // subnormals kept unnormalised with exponent 1; renormalised after the add
    assign ea = (a[62:52] == '0) ? 13'sd1 : {2'b0, a[62:52]};
    assign eb = (b[62:52] == '0) ? 13'sd1 : {2'b0, b[62:52]};
    assign ma = {(a[62:52] != '0), a[51:0], 3'b0};
    assign mb = {(b[62:52] != '0), b[51:0], 3'b0};
    assign swap = (ea < eb);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            spec1_reg  <= spec;
            sbits1_reg <= spec_bits;
            sa1_reg    <= swap ? b[63] : a[63];
            sb1_reg    <= swap ? a[63] : b[63];
            ex1_reg    <= swap ? eb : ea;
            d1_reg     <= swap ? (eb - ea) : (ea - eb);
            mbig1_reg  <= swap ? mb : ma;
            msml1_reg  <= swap ? ma : mb;
        end
    end

    always_comb
    begin
        if (d1_reg > 13'd60)
        begin
            shifted  = '0;
            lostmask = '1;
        end
        else
        begin
            shifted  = msml1_reg >> d1_reg[5:0];
            lostmask = ~({56{1'b1}} << d1_reg[5:0]);
        end
        mb_al = shifted | {55'd0, |(msml1_reg & lostmask)};
    end

    always_comb
    begin
        mid2_next              = '0;
        mid2_next.special      = spec1_reg;
        mid2_next.special_bits = sbits1_reg;
        mid2_next.ex           = ex1_reg;
        if (sa1_reg == sb1_reg)
        begin
            mid2_next.sign = sa1_reg;
            mid2_next.sig  = {1'b0, mbig1_reg} + {1'b0, mb_al};
        end
        else if (mbig1_reg >= mb_al)
        begin
            mid2_next.sign = (mbig1_reg == mb_al) ? 1'b0 : sa1_reg;
            mid2_next.sig  = {1'b0, mbig1_reg - mb_al};
        end
        else
        begin
            mid2_next.sign = sb1_reg;
            mid2_next.sig  = {1'b0, mb_al - mbig1_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            mid2_reg <= mid2_next;
    end

    assign out_valid = v2_reg;
    assign out_mid   = mid2_reg;

endmodule

// File: hw/rtl/dfas_round.sv
// ----------------------------------------------------------------------------
// dfas_round
// Stage 3-4: normalise, denormalise tiny results, round and pack.
// ----------------------------------------------------------------------------
module dfas_round
    import dfas_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  dfas_mid_t   in_mid,
    output logic        out_valid,
    output logic [63:0] out_bits
);

    // value = sig * 2^(ex - bias - 55), sig is 57 bits (carry in bit 56)
    logic [5:0]  lz;
    logic signed [14:0] e_norm;
    logic [6:0]  lsh;
    logic [56:0] sig_n;

    logic        v3_reg, spec3_reg, sign3_reg, zero3_reg;
    logic [63:0] sbits3_reg;
    logic [56:0] sig3_reg;
    logic signed [14:0] e3_reg;

    logic [56:0] den, lost;
    logic [56:0] sig_d;
    logic signed [14:0] e_d;
    logic [2:0]  grs;
    logic [53:0] keep;
    logic [10:0] ef;
    logic [63:0] res;

    logic        v4_reg;
    logic [63:0] out4_reg;

    assign lz = dfas_lzc(in_mid.sig);

    always_comb
    begin
        // target: leading one in bit 55, e_norm is biased exponent
        e_norm = $signed({2'b0, in_mid.ex}) + 15'sd1 - $signed({9'd0, lz});
        lsh    = '0;
        if (lz == 6'd0)
            sig_n = in_mid.sig;
        else
        begin
            lsh   = {1'b0, lz} - 7'd1;
            sig_n = in_mid.sig << lsh[5:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            spec3_reg  <= in_mid.special;
            sbits3_reg <= in_mid.special_bits;
            sign3_reg  <= in_mid.sign;
            zero3_reg  <= (in_mid.sig == '0);
            sig3_reg   <= sig_n;
            e3_reg     <= e_norm;
        end
    end

    always_comb
    begin
        // sig3_reg: bit 56 set means one too high; fold to bit 55 with sticky
        // (e3_reg already counts that extra bit)
        logic [55:0] s;
        logic signed [14:0] e;
        logic [6:0] sh;
        if (sig3_reg[56])
        begin
            s = sig3_reg[56:1] | {55'd0, sig3_reg[0]};
            e = e3_reg;
        end
        else
        begin
            s = sig3_reg[55:0];
            e = e3_reg;
        end
        den   = {1'b0, s};
        lost  = '0;
        e_d   = e;
        sh    = '0;
        if (e < 15'sd1)
        begin
            sh   = (e < -15'sd62) ? 7'd63 : 7'(15'sd1 - e);
            den  = {1'b0, s} >> sh[5:0];
            lost = ~({57{1'b1}} << sh[5:0]);
            e_d  = 15'sd0;
        end
        sig_d = den | {56'd0, |({1'b0, s} & lost)};
        grs   = sig_d[2:0];
        keep  = {1'b0, sig_d[55:3]};
        if (grs > 3'd4 || (grs == 3'd4 && keep[0]))
            keep = keep + 54'd1;
        ef = e_d[10:0];
        if (e_d == 15'sd0)
        begin
            res = {sign3_reg, 11'd0, 52'd0} | {10'd0, keep};
        end
        else
        begin
            if (keep[53])
            begin
                keep = keep >> 1;
                ef   = ef + 11'd1;
            end
            if (e_d > 15'sd2046 || (e_d == 15'sd2046 && ef == 11'h7ff))
                res = {sign3_reg, 11'h7ff, 52'd0};
            else
                res = {sign3_reg, ef, keep[51:0]};
        end
        if (zero3_reg)
            res = 64'd0;
        if (spec3_reg)
            res = sbits3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (en)
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out4_reg <= res;
    end

    assign out_valid = v4_reg;
    assign out_bits  = out4_reg;

endmodule

// File: hw/rtl/double_float_add_sub.sv
// ----------------------------------------------------------------------------
// double_float_add_sub
// Binary64 add/subtract, round to nearest even, four-stage pipeline.
// ----------------------------------------------------------------------------
// One request enters per cycle while the pipeline is not stalled; each result
// passes through four register stages (unpack and order, align and add,
// normalise, round/pack). A stall on the output freezes the whole pipeline,
// so in_stall follows out_stall whenever the final stage holds a result.
module double_float_add_sub
    import dfas_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [63:0] operand_a,
    input  logic [63:0] operand_b,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] sum_bits
);

    logic      en;
    logic      mid_valid;
    dfas_mid_t mid;

    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    dfas_align u_align (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .req_type  (req_type),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .out_valid (mid_valid),
        .out_mid   (mid)
    );

    dfas_round u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (mid_valid),
        .in_mid    (mid),
        .out_valid (out_valid),
        .out_bits  (sum_bits)
    );

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the binary64 add/subtract pipeline: directed special
// operands, then random requests weighted towards hard cases, each result
// compared against an in-bench rounding predictor.
// ----------------------------------------------------------------------------
module tb_top;
    import dfas_pkg::*;

    localparam logic [63:0] SIGN_MASK = 64'h8000000000000000;
    localparam logic [63:0] FRAC_MASK = 64'h000fffffffffffff;
    localparam logic [63:0] POS_INF   = 64'h7ff0000000000000;
    localparam logic        OP_ADD    = 1'b0;
    localparam logic        OP_SUB    = 1'b1;
    localparam int          EMIN      = -1022;
    localparam int          N_RANDOM  = 1700;
    localparam int          HOLD_LEN  = 60;

    typedef struct packed {
        logic        op;
        logic [63:0] a;
        logic [63:0] b;
    } dreq_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        req_type;
    logic [63:0] operand_a;
    logic [63:0] operand_b;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] sum_bits;

    dreq_t       pending_q[$];
    logic [63:0] sum_expect_q[$];
    int          errors;
    int          results_seen;
    int          sent_count;
    int          tx_gap;
    int          rx_gap;
    int          hold_cnt;
    bit          hold_done;

    double_float_add_sub u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sum_bits  (sum_bits)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic logic [63:0] sticky_shr(input logic [63:0] s, input int n);
        logic [63:0] r;
        r = s;
        for (int i = 0; i < n; i++)
        begin
            r = (r >> 1) | (r & 64'd1);
        end
        return r;
    endfunction

    function automatic logic [63:0] pack_rounded(input logic neg, input int ex_in,
                                                 input logic [63:0] sig_in);
        logic [63:0] sbit;
        logic [63:0] sig;
        logic [63:0] keep;
        logic [2:0]  grs;
        int          ex;
        sbit = neg ? SIGN_MASK : 64'd0;
        sig  = sig_in;
        ex   = ex_in;
        if (sig == 0)
            return sbit;
        while (sig < (64'd1 << 55))
        begin
            sig = sig << 1;
            ex--;
        end
        while (sig >= (64'd1 << 56))
        begin
            sig = sticky_shr(sig, 1);
            ex++;
        end
        if (ex < EMIN)
        begin
            if (EMIN - ex > 63)
                return sbit;
            sig  = sticky_shr(sig, EMIN - ex);
            grs  = sig[2:0];
            keep = sig >> 3;
            if (grs > 3'd4 || (grs == 3'd4 && keep[0]))
                keep++;
            return sbit | keep;
        end
        grs  = sig[2:0];
        keep = sig >> 3;
        if (grs > 3'd4 || (grs == 3'd4 && keep[0]))
        begin
            keep++;
            if (keep >= (64'd1 << 53))
            begin
                keep = keep >> 1;
                ex++;
            end
        end
        if (ex > EXP_BIAS)
            return sbit | POS_INF;
        return sbit | (64'(ex + EXP_BIAS) << 52) | (keep & FRAC_MASK);
    endfunction

    function automatic void unpack_finite(input logic [63:0] x, output int ex,
                                          output logic [63:0] sig);
        logic [63:0] f;
        f = x & FRAC_MASK;
        if (x[62:52] == 0)
        begin
            ex = EMIN;
            f  = f << 3;
            while (f < (64'd1 << 55))
            begin
                f = f << 1;
                ex--;
            end
            sig = f;
        end
        else
        begin
            ex  = int'(x[62:52]) - EXP_BIAS;
            sig = (f | (64'd1 << 52)) << 3;
        end
    endfunction

    function automatic logic [63:0] predict_sum(input dreq_t r);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] tu;
        logic [63:0] lost;
        logic        sa;
        logic        sb;
        logic        ts;
        int          ea;
        int          eb;
        int          ti;
        int          d;
        a = r.a;
        b = r.b;
        if (r.op == OP_SUB)
            b = b ^ SIGN_MASK;
        if ((a[62:52] == 11'h7ff && a[51:0] != 0) || (b[62:52] == 11'h7ff && b[51:0] != 0))
            return QNAN_BITS;
        if (a[62:52] == 11'h7ff)
        begin
            if (b[62:52] == 11'h7ff && a[63] != b[63])
                return QNAN_BITS;
            return a;
        end
        if (b[62:52] == 11'h7ff)
            return b;
        if (a[62:0] == 0)
        begin
            if (b[62:0] == 0)
                return a & b & SIGN_MASK;
            return b;
        end
        if (b[62:0] == 0)
            return a;
        sa = a[63];
        sb = b[63];
        unpack_finite(a, ea, ma);
        unpack_finite(b, eb, mb);
        if (ea < eb)
        begin
            ti = ea; ea = eb; eb = ti;
            tu = ma; ma = mb; mb = tu;
            ts = sa; sa = sb; sb = ts;
        end
        d = ea - eb;
        if (d > 60)
            mb = (mb != 0) ? 64'd1 : 64'd0;
        else if (d > 0)
        begin
            lost = mb & ((64'd1 << d) - 1);
            mb   = mb >> d;
            if (lost != 0)
                mb = mb | 64'd1;
        end
        if (sa == sb)
            return pack_rounded(sa, ea, ma + mb);
        if (ma == mb)
            return 64'd0;
        if (ma > mb)
            return pack_rounded(sa, ea, ma - mb);
        return pack_rounded(sb, ea, mb - ma);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // biased operand: specials, subnormals, extreme exponents or raw bits
    function automatic logic [63:0] pick_operand();
        logic [63:0] x;
        x = rand64();
        case ($urandom_range(0, 9))
            0: x[62:52] = 11'h7ff;
            1: x[62:52] = 11'h000;
            2: x[62:52] = 11'h7fe - 11'($urandom_range(0, 2));
            3: x[62:0]  = 63'd0;
            4: x[62:52] = 11'($urandom_range(0, 3));
            default: ;
        endcase
        return x;
    endfunction

    function automatic dreq_t make_random();
        dreq_t r;
        r.op = 1'($urandom_range(0, 1));
        r.a  = pick_operand();
        case ($urandom_range(0, 5))
            0: r.b = r.a ^ (r.op == OP_SUB ? 64'd0 : SIGN_MASK);
            1: r.b = {r.a[63:52] + 12'($urandom_range(0, 4)) - 12'd2, 52'(rand64())};
            2: r.b = r.a ^ 64'($urandom_range(1, 15)) ^ (64'($urandom_range(0, 1)) << 63);
            default: r.b = pick_operand();
        endcase
        return r;
    endfunction

    task automatic push_req(input logic op, input logic [63:0] a, input logic [63:0] b);
        dreq_t r;
        r.op = op;
        r.a  = a;
        r.b  = b;
        pending_q.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            req_type   <= OP_ADD;
            operand_a  <= 64'd0;
            operand_b  <= 64'd0;
            tx_gap     <= 0;
            sent_count <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                sum_expect_q.push_back(predict_sum({req_type, operand_a, operand_b}));
                sent_count <= sent_count + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (tx_gap > 0 || pending_q.size() == 0)
                begin
                    in_valid <= 1'b0;
                    if (tx_gap > 0)
                        tx_gap <= tx_gap - 1;
                end
                else
                begin
                    dreq_t r;
                    r = pending_q.pop_front();
                    in_valid  <= 1'b1;
                    req_type  <= r.op;
                    operand_a <= r.a;
                    operand_b <= r.b;
                    tx_gap    <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : 0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall    <= 1'b0;
            rx_gap       <= 0;
            hold_cnt     <= 0;
            hold_done    <= 1'b0;
            results_seen <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen <= results_seen + 1;
                if (sum_expect_q.size() == 0)
                begin
                    $error("unexpected result sum_bits=%h", sum_bits);
                    errors++;
                end
                else
                begin
                    logic [63:0] want;
                    want = sum_expect_q.pop_front();
                    if (sum_bits !== want)
                    begin
                        $error("sum_bits mismatch: expected %h actual %h", want, sum_bits);
                        errors++;
                    end
                end
            end
            // one long hold-off once traffic is flowing, to back up the pipe
            if (!hold_done && sent_count > 200)
            begin
                if (hold_cnt == HOLD_LEN)
                begin
                    hold_done <= 1'b1;
                    out_stall <= 1'b0;
                end
                else
                begin
                    out_stall <= 1'b1;
                    hold_cnt  <= hold_cnt + 1;
                end
            end
            else if (rx_gap > 0)
            begin
                out_stall <= 1'b1;
                rx_gap    <= rx_gap - 1;
            end
            else
            begin
                out_stall <= 1'b0;
                if (out_valid && !out_stall && sent_count > 600)
                    rx_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : 0;
            end
        end
    end

    initial
    begin
        logic [63:0] min_sub;
        logic [63:0] max_sub;
        logic [63:0] min_nrm;
        logic [63:0] max_fin;
        logic [63:0] one;
        errors    = 0;
        rst_n     = 1'b0;
        min_sub = 64'h0000000000000001;
        max_sub = 64'h000fffffffffffff;
        min_nrm = 64'h0010000000000000;
        max_fin = 64'h7fefffffffffffff;
        one     = 64'h3ff0000000000000;
        push_req(OP_ADD, one, one);
        push_req(OP_SUB, one, one);
        push_req(OP_ADD, 64'h7ff0000000000001, one);
        push_req(OP_ADD, one, 64'hfff8000000000000);
        push_req(OP_ADD, POS_INF, POS_INF | SIGN_MASK);
        push_req(OP_SUB, POS_INF, POS_INF);
        push_req(OP_ADD, POS_INF, POS_INF);
        push_req(OP_SUB, one, POS_INF);
        push_req(OP_ADD, SIGN_MASK, SIGN_MASK);
        push_req(OP_SUB, SIGN_MASK, 64'd0);
        push_req(OP_ADD, SIGN_MASK, 64'd0);
        push_req(OP_ADD, 64'd0, max_sub | SIGN_MASK);
        push_req(OP_SUB, max_fin, 64'd0);
        push_req(OP_ADD, max_fin, max_fin);
        push_req(OP_ADD, max_fin, 64'h7ca0000000000000);
        push_req(OP_ADD, min_sub, min_sub);
        push_req(OP_ADD, max_sub, min_sub);
        push_req(OP_SUB, min_nrm, min_sub);
        push_req(OP_ADD, one, min_sub);
        push_req(OP_ADD, one, 64'h3ca0000000000000);
        push_req(OP_ADD, 64'h3ff0000000000001, 64'h3ca0000000000000);
        push_req(OP_SUB, 64'h3ff0000000000000, 64'h3fefffffffffffff);
        push_req(OP_ADD, 64'hffffffffffffffff, 64'h0123456789abcdef);
        push_req(OP_SUB, 64'hffefffffffffffff, max_fin);
        for (int i = 0; i < N_RANDOM; i++)
            pending_q.push_back(make_random());
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_q.size() == 0);
        @(posedge clk);
        while (in_valid)
            @(posedge clk);
        while (sum_expect_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("Ran %0d requests (directed specials plus weighted random), %0d results checked.",
                 sent_count, results_seen);
        $display("Included one long output hold-off of %0d cycles.", HOLD_LEN);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #200000;
        $display("Verification failed");
        $finish;
    end

endmodule
